/* hdl/pvs_pkg.sv */
// ----------------------------------------------------------------------------
// pvs_pkg: shared types and helpers for the polynomial value and slope block
// Widths of the fixed-point datapath, default parameter values and the
// clipping functions used by the Horner steps and the final narrowing.
// ----------------------------------------------------------------------------
package pvs_pkg;

  // field and datapath widths
  localparam int unsigned X_W       = 32;               // sample width
  localparam int unsigned COEF_W    = 32;               // coefficient width
  localparam int unsigned OUT_W     = 32;               // result width
  localparam int unsigned ACC_W     = 48;               // accumulator width
  localparam int unsigned SPLIT_W   = 16;               // low slice of the multiplicand
  localparam int unsigned HI_W      = ACC_W - SPLIT_W;  // high slice, signed
  localparam int unsigned HI_PP_W   = HI_W + X_W;       // high partial product
  localparam int unsigned LO_PP_W   = SPLIT_W + 1 + X_W; // low partial product
  localparam int unsigned PROD_W    = ACC_W + X_W;      // full product

  // register file
  localparam int unsigned NUM_COEF  = 8;
  localparam int unsigned COEF_IDX_W = $clog2(NUM_COEF);
  localparam int unsigned CFG_IDX_W = COEF_IDX_W + 1;

  // parameter defaults
  localparam int unsigned MAX_DEGREE_DEF = 7;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [OUT_W-1:0] res_t;

  typedef struct packed {
    logic sat;
    acc_t val;
  } acc_sat_t;

  typedef struct packed {
    logic sat;
    res_t val;
  } res_sat_t;

  // Clip a shifted full-width product into the accumulator range
  function automatic acc_sat_t clip_prod(input logic signed [PROD_W-1:0] w);
    logic [PROD_W-ACC_W:0] top;
    acc_sat_t              r;
    top = w[PROD_W-1:ACC_W-1];
    if ((&top) || !(|top)) begin
      r.sat = 1'b0;
      r.val = w[ACC_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = w[PROD_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturating accumulator add
  function automatic acc_sat_t add_acc(input acc_t a, input acc_t b);
    logic [ACC_W:0] s;
    acc_sat_t       r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] == s[ACC_W-1]) begin
      r.sat = 1'b0;
      r.val = s[ACC_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Narrow an accumulator value to the result width
  function automatic res_sat_t clip_out(input acc_t a);
    logic [ACC_W-OUT_W:0] top;
    res_sat_t             r;
    top = a[ACC_W-1:OUT_W-1];
    if ((&top) || !(|top)) begin
      r.sat = 1'b0;
      r.val = a[OUT_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = a[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* hdl/polynomial_value_and_slope_top.sv */
// ----------------------------------------------------------------------------
// polynomial_value_and_slope_top: pipelined Horner evaluator with derivative
// Evaluates p(x) and p'(x) for a fixed-point polynomial of degree up to
// MAX_DEGREE, with coefficients held in configuration registers.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+--------------------------
//  input   | start, busy, in_x_value                 | start & !busy
//  result  | out_valid, out_poly_value,              | out_valid (one cycle)
//          | out_slope_value, out_saturated          |
//  config  | cfg_valid, cfg_ready, cfg_index,        | cfg_valid & cfg_ready
//          | cfg_data                                |
//
//  One sample enters per clock; busy stays low. Each Horner step takes three
//  register stages (partial products, product recombine and floor, add), plus
//  one output register: a result passes through every step's registers and
//  then through the output register before it is on the ports.
//  The 48x32 multiply, split into a 32x32 and a 17x32 product, sets the stage
//  depth. Synchronous reset clears the valid bits and the coefficients.
//  The receiver cannot stall, so the pipeline never holds.
//
module polynomial_value_and_slope_top #(
  parameter int unsigned MAX_DEGREE = pvs_pkg::MAX_DEGREE_DEF,
  parameter int unsigned FRAC_BITS  = pvs_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample input
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [pvs_pkg::X_W-1:0]        in_x_value,
  // results
  output logic                                  out_valid,
  output logic signed [pvs_pkg::OUT_W-1:0]      out_poly_value,
  output logic signed [pvs_pkg::OUT_W-1:0]      out_slope_value,
  output logic                                  out_saturated,
  // coefficient writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pvs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pvs_pkg::COEF_W-1:0]            cfg_data
);

  localparam int unsigned LATENCY = 3 * MAX_DEGREE + 1;

  // coefficient registers
  logic signed [pvs_pkg::COEF_W-1:0] coef_r [pvs_pkg::NUM_COEF];

  // stage A: partial products
  logic [MAX_DEGREE-1:0]                  a_vld_r, a_vld_nxt;
  logic [MAX_DEGREE-1:0]                  a_sat_r, a_sat_nxt;
  logic signed [pvs_pkg::X_W-1:0]         a_x_r     [MAX_DEGREE];
  logic signed [pvs_pkg::X_W-1:0]         a_x_nxt   [MAX_DEGREE];
  pvs_pkg::acc_t                          a_v_r     [MAX_DEGREE];
  pvs_pkg::acc_t                          a_v_nxt   [MAX_DEGREE];
  logic signed [pvs_pkg::HI_PP_W-1:0]     a_dhi_r   [MAX_DEGREE];
  logic signed [pvs_pkg::HI_PP_W-1:0]     a_dhi_nxt [MAX_DEGREE];
  logic signed [pvs_pkg::LO_PP_W-1:0]     a_dlo_r   [MAX_DEGREE];
  logic signed [pvs_pkg::LO_PP_W-1:0]     a_dlo_nxt [MAX_DEGREE];
  logic signed [pvs_pkg::HI_PP_W-1:0]     a_vhi_r   [MAX_DEGREE];
  logic signed [pvs_pkg::HI_PP_W-1:0]     a_vhi_nxt [MAX_DEGREE];
  logic signed [pvs_pkg::LO_PP_W-1:0]     a_vlo_r   [MAX_DEGREE];
  logic signed [pvs_pkg::LO_PP_W-1:0]     a_vlo_nxt [MAX_DEGREE];

  // stage B: floored, clipped products
  logic [MAX_DEGREE-1:0]                  b_vld_r, b_vld_nxt;
  logic [MAX_DEGREE-1:0]                  b_sat_r, b_sat_nxt;
  logic signed [pvs_pkg::X_W-1:0]         b_x_r     [MAX_DEGREE];
  logic signed [pvs_pkg::X_W-1:0]         b_x_nxt   [MAX_DEGREE];
  pvs_pkg::acc_t                          b_v_r     [MAX_DEGREE];
  pvs_pkg::acc_t                          b_v_nxt   [MAX_DEGREE];
  pvs_pkg::acc_t                          b_dp_r    [MAX_DEGREE];
  pvs_pkg::acc_t                          b_dp_nxt  [MAX_DEGREE];
  pvs_pkg::acc_t                          b_vp_r    [MAX_DEGREE];
  pvs_pkg::acc_t                          b_vp_nxt  [MAX_DEGREE];

  // stage C: new value and slope accumulators
  logic [MAX_DEGREE-1:0]                  c_vld_r, c_vld_nxt;
  logic [MAX_DEGREE-1:0]                  c_sat_r, c_sat_nxt;
  logic signed [pvs_pkg::X_W-1:0]         c_x_r     [MAX_DEGREE];
  logic signed [pvs_pkg::X_W-1:0]         c_x_nxt   [MAX_DEGREE];
  pvs_pkg::acc_t                          c_v_r     [MAX_DEGREE];
  pvs_pkg::acc_t                          c_v_nxt   [MAX_DEGREE];
  pvs_pkg::acc_t                          c_d_r     [MAX_DEGREE];
  pvs_pkg::acc_t                          c_d_nxt   [MAX_DEGREE];

  // recombine scratch
  logic signed [pvs_pkg::PROD_W-1:0]      d_prod    [MAX_DEGREE];
  logic signed [pvs_pkg::PROD_W-1:0]      v_prod    [MAX_DEGREE];

  // output register
  logic                                   out_vld_r, out_vld_nxt;
  logic                                   out_sat_r, out_sat_nxt;
  pvs_pkg::res_t                          out_poly_r, out_poly_nxt;
  pvs_pkg::res_t                          out_slope_r, out_slope_nxt;

  pvs_pkg::res_sat_t                      fin_v, fin_d;

  // never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // coefficient register writes; indexes past the file are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pvs_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < pvs_pkg::CFG_IDX_W'(pvs_pkg::NUM_COEF))) begin
      coef_r[cfg_index[pvs_pkg::COEF_IDX_W-1:0]] <= cfg_data;
    end
  end

  // stage A: split each multiplicand, form partial products
  always_comb begin
    pvs_pkg::acc_t d_in;
    pvs_pkg::acc_t v_in;
    logic signed [pvs_pkg::X_W-1:0] x_in;
    for (int j = 0; j < MAX_DEGREE; j++) begin
      if (j == 0) begin
        a_vld_nxt[j] = start && !busy;
        a_sat_nxt[j] = 1'b0;
        x_in = in_x_value;
        v_in = pvs_pkg::ACC_W'(coef_r[MAX_DEGREE]);
        d_in = '0;
      end else begin
        a_vld_nxt[j] = c_vld_r[j-1];
        a_sat_nxt[j] = c_sat_r[j-1];
        x_in = c_x_r[j-1];
        v_in = c_v_r[j-1];
        d_in = c_d_r[j-1];
      end
      a_x_nxt[j]   = x_in;
      a_v_nxt[j]   = v_in;
      a_dhi_nxt[j] = $signed(d_in[pvs_pkg::ACC_W-1:pvs_pkg::SPLIT_W]) * x_in;
      a_dlo_nxt[j] = $signed({1'b0, d_in[pvs_pkg::SPLIT_W-1:0]}) * x_in;
      a_vhi_nxt[j] = $signed(v_in[pvs_pkg::ACC_W-1:pvs_pkg::SPLIT_W]) * x_in;
      a_vlo_nxt[j] = $signed({1'b0, v_in[pvs_pkg::SPLIT_W-1:0]}) * x_in;
    end
  end

  // stage B: recombine, floor by the fraction bits, clip to the accumulator
  always_comb begin
    pvs_pkg::acc_sat_t dq;
    pvs_pkg::acc_sat_t vq;
    for (int j = 0; j < MAX_DEGREE; j++) begin
      d_prod[j] = {a_dhi_r[j], {pvs_pkg::SPLIT_W{1'b0}}}
                + {{(pvs_pkg::PROD_W-pvs_pkg::LO_PP_W){a_dlo_r[j][pvs_pkg::LO_PP_W-1]}},
                   a_dlo_r[j]};
      v_prod[j] = {a_vhi_r[j], {pvs_pkg::SPLIT_W{1'b0}}}
                + {{(pvs_pkg::PROD_W-pvs_pkg::LO_PP_W){a_vlo_r[j][pvs_pkg::LO_PP_W-1]}},
                   a_vlo_r[j]};
      dq = pvs_pkg::clip_prod(d_prod[j] >>> FRAC_BITS);
      vq = pvs_pkg::clip_prod(v_prod[j] >>> FRAC_BITS);
      b_vld_nxt[j] = a_vld_r[j];
      b_sat_nxt[j] = a_sat_r[j] | dq.sat | vq.sat;
      b_x_nxt[j]   = a_x_r[j];
      b_v_nxt[j]   = a_v_r[j];
      b_dp_nxt[j]  = dq.val;
      b_vp_nxt[j]  = vq.val;
    end
  end

  // stage C: d = d*x + v (old v), v = v*x + c[k]
  always_comb begin
    pvs_pkg::acc_sat_t ds;
    pvs_pkg::acc_sat_t vs;
    for (int j = 0; j < MAX_DEGREE; j++) begin
      ds = pvs_pkg::add_acc(b_dp_r[j], b_v_r[j]);
      vs = pvs_pkg::add_acc(b_vp_r[j],
                            pvs_pkg::ACC_W'(coef_r[MAX_DEGREE-1-j]));
      c_vld_nxt[j] = b_vld_r[j];
      c_sat_nxt[j] = b_sat_r[j] | ds.sat | vs.sat;
      c_x_nxt[j]   = b_x_r[j];
      c_d_nxt[j]   = ds.val;
      c_v_nxt[j]   = vs.val;
    end
  end

  // final narrowing to the result width
  always_comb begin
    fin_v         = pvs_pkg::clip_out(c_v_r[MAX_DEGREE-1]);
    fin_d         = pvs_pkg::clip_out(c_d_r[MAX_DEGREE-1]);
    out_vld_nxt   = c_vld_r[MAX_DEGREE-1];
    out_sat_nxt   = c_sat_r[MAX_DEGREE-1] | fin_v.sat | fin_d.sat;
    out_poly_nxt  = fin_v.val;
    out_slope_nxt = fin_d.val;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= '0;
      b_vld_r   <= '0;
      c_vld_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      a_vld_r   <= a_vld_nxt;
      b_vld_r   <= b_vld_nxt;
      c_vld_r   <= c_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_sat_r <= a_sat_nxt;
    b_sat_r <= b_sat_nxt;
    c_sat_r <= c_sat_nxt;
    for (int j = 0; j < MAX_DEGREE; j++) begin
      a_x_r[j]   <= a_x_nxt[j];
      a_v_r[j]   <= a_v_nxt[j];
      a_dhi_r[j] <= a_dhi_nxt[j];
      a_dlo_r[j] <= a_dlo_nxt[j];
      a_vhi_r[j] <= a_vhi_nxt[j];
      a_vlo_r[j] <= a_vlo_nxt[j];
      b_x_r[j]   <= b_x_nxt[j];
      b_v_r[j]   <= b_v_nxt[j];
      b_dp_r[j]  <= b_dp_nxt[j];
      b_vp_r[j]  <= b_vp_nxt[j];
      c_x_r[j]   <= c_x_nxt[j];
      c_v_r[j]   <= c_v_nxt[j];
      c_d_r[j]   <= c_d_nxt[j];
    end
    out_sat_r   <= out_sat_nxt;
    out_poly_r  <= out_poly_nxt;
    out_slope_r <= out_slope_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_saturated   = out_sat_r;
  assign out_poly_value  = out_poly_r;
  assign out_slope_value = out_slope_r;

`ifndef NO_ASSERTIONS
  // every sample transfer is followed by a result on out_valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after sample transfer");

  // no result without a matching earlier sample transfer
  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching sample transfer");

  // a clipped result must carry the saturation flag
  a_clip_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (c_vld_r[MAX_DEGREE-1] && (fin_v.sat || fin_d.sat)) |=> out_saturated)
    else $error("clipped result without saturation flag");
`endif

endmodule
